// ----- sv/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared types and constants for the pixel pipeline and its channel lanes.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Saturated channel byte and opaque alpha
	localparam logic [7:0] BYTE_MAX   = 8'hFF;
	localparam logic [7:0] ALPHA_BYTE = 8'hFF;

	// Per-stage load enables handed from the pipeline control to each lane
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} hsv2rgb_ld_t;

endpackage

// ----- sv/hsv2rgb_if.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB pixel stream interfaces
// Valid/ready channels for HSV pixels in and RGB pixels out.
// ----------------------------------------------------------------------------
interface hsv2rgb_pix_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] hue_angle;
	logic [15:0] saturation;
	logic [15:0] brightness;

	modport source (output valid, hue_angle, saturation, brightness, input ready);
	modport sink   (input valid, hue_angle, saturation, brightness, output ready);
endinterface

interface hsv2rgb_pix_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [31:0] packed_argb;

	modport source (output valid, red, green, blue, packed_argb, input ready);
	modport sink   (input valid, red, green, blue, packed_argb, output ready);
endinterface

// ----- sv/hsv2rgb_chan.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB channel lane
// Turns V, S and the hue weight m of one channel into its byte:
// floor(V * (ONE*D - S*m) * 17 / 2^(HFB + 2 + 2*LFB)), clamped and saturated.
// ----------------------------------------------------------------------------
module hsv2rgb_chan #(
	parameter int HUE_FRAC_BITS   = 6,
	parameter int LEVEL_FRAC_BITS = 15
) (
	input  logic                       clk,
	input  hsv2rgb_pkg::hsv2rgb_ld_t   ld,
	input  logic [15:0]                sat_s1,
	input  logic [15:0]                val_s1,
	input  logic [HUE_FRAC_BITS+5:0]   weight_s1,
	output logic [7:0]                 chan_byte_s5
);

	localparam int MW     = HUE_FRAC_BITS + 6;
	localparam int SUBW   = 16 + MW;
	localparam int NUMW   = LEVEL_FRAC_BITS + HUE_FRAC_BITS + 6;
	localparam int CMPW   = (SUBW > NUMW) ? SUBW : NUMW;
	localparam int LOW_W  = (NUMW + 1) / 2;
	localparam int HIGH_W = NUMW - LOW_W;
	localparam int PLW    = 16 + LOW_W;
	localparam int PHW    = 16 + HIGH_W;
	localparam int PRODW  = 16 + NUMW;
	localparam int XW     = PRODW + 5;
	localparam int SH     = HUE_FRAC_BITS + 2 + 2 * LEVEL_FRAC_BITS;
	// ONE * D = 15 << (LFB + HFB + 2)
	localparam logic [CMPW-1:0] WHOLE =
		CMPW'(15) << (LEVEL_FRAC_BITS + HUE_FRAC_BITS + 2);

	logic [SUBW-1:0]   sub_s2;
	logic [15:0]       val_s2;
	logic [NUMW-1:0]   num_s3;
	logic [15:0]       val_s3;
	logic [PLW-1:0]    plo_s4;
	logic [PHW-1:0]    phi_s4;

	logic [CMPW-1:0]   sub_ext;
	logic [PRODW-1:0]  prod;
	logic [XW-1:0]     prod_x17;
	logic [XW-1:0]     level;

	// Stage 2: S times weight
	always_ff @(posedge clk) begin
		if (ld.s2) begin
			sub_s2 <= SUBW'(sat_s1) * SUBW'(weight_s1);
			val_s2 <= val_s1;
		end
	end

	// Stage 3: numerator, clamp negative terms to zero
	assign sub_ext = CMPW'(sub_s2);

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			num_s3 <= (sub_ext >= WHOLE) ? '0 : NUMW'(WHOLE - sub_ext);
			val_s3 <= val_s2;
		end
	end

	// Stage 4: V times numerator as two partial products
	always_ff @(posedge clk) begin
		if (ld.s4) begin
			plo_s4 <= PLW'(val_s3) * PLW'(num_s3[LOW_W-1:0]);
			phi_s4 <= PHW'(val_s3) * PHW'(num_s3[NUMW-1:LOW_W]);
		end
	end

	// Stage 5: combine, scale by 17, drop fraction, saturate
	assign prod     = (PRODW'(phi_s4) << LOW_W) + PRODW'(plo_s4);
	assign prod_x17 = (XW'(prod) << 4) + XW'(prod);
	assign level    = prod_x17 >> SH;

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			chan_byte_s5 <= (|level[XW-1:8]) ? hsv2rgb_pkg::BYTE_MAX : level[7:0];
		end
	end

endmodule

// ----- sv/hsv_to_rgb_pixel_converter_top.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB pixel converter
// Hexcone conversion of a pixel stream, five register stages deep.
// ----------------------------------------------------------------------------
// A pixel passes through stages s1 to s5 in order, from input transfer to output valid.
// Throughput: one pixel per cycle while the output is ready; each stage holds one pixel and the
// widest step, V times the clamped numerator, is split over two stages.
// A stall holds only the stages behind it; empty stages still fill.
// Reset clears the stage valid bits; data registers are not reset.
module hsv_to_rgb_pixel_converter_top #(
	parameter int HUE_FRAC_BITS   = 6,
	parameter int LEVEL_FRAC_BITS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	hsv2rgb_pix_in_if.sink    pix_in,
	hsv2rgb_pix_out_if.source pix_out
);

	localparam int MW = HUE_FRAC_BITS + 6;
	localparam int unsigned SECT_W    = 60 << HUE_FRAC_BITS;
	localparam int unsigned FULL_TURN = 360 << HUE_FRAC_BITS;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	logic [15:0]    hue_w;
	logic [15:0]    hue_coarse;
	sector_t        sector;
	logic [31:0]    sect_base;
	logic [MW-1:0]  rem;
	logic [MW-1:0]  rem_c;
	logic [MW-1:0]  m_r, m_g, m_b;

	logic           vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic           adv1, adv2, adv3, adv4, adv5;
	hsv2rgb_pkg::hsv2rgb_ld_t ld;

	logic [15:0]    sat_s1;
	logic [15:0]    val_s1;
	logic [MW-1:0]  m_r_s1, m_g_s1, m_b_s1;
	logic [7:0]     red_s5, green_s5, blue_s5;

	// Advance a stage when it is empty or its successor advances
	assign adv5 = !vld_s5 || pix_out.ready;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign pix_in.ready = adv1;
	assign ld = '{s2: adv2, s3: adv3, s4: adv4, s5: adv5};

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= pix_in.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
		end
	end

	// Wrap out-of-range hue to zero, find sector and remainder
	assign hue_w      = (32'(pix_in.hue_angle) >= FULL_TURN) ? 16'd0 : pix_in.hue_angle;
	assign hue_coarse = hue_w >> (HUE_FRAC_BITS + 2);
	assign sector     = sector_t'(3'(hue_coarse >= 16'd15) + 3'(hue_coarse >= 16'd30)
		+ 3'(hue_coarse >= 16'd45) + 3'(hue_coarse >= 16'd60)
		+ 3'(hue_coarse >= 16'd75));
	assign sect_base  = 32'(sector) * SECT_W;
	assign rem        = MW'(32'(hue_w) - sect_base);
	assign rem_c      = MW'(SECT_W) - rem;

	// Pick each channel's weight: 0 for V, D for p, rem for q, D-rem for t
	always_comb begin
		unique case (sector)
			SEC_RED: begin
				m_r = '0;         m_g = rem_c;      m_b = MW'(SECT_W);
			end
			SEC_YELLOW: begin
				m_r = rem;        m_g = '0;         m_b = MW'(SECT_W);
			end
			SEC_GREEN: begin
				m_r = MW'(SECT_W); m_g = '0;        m_b = rem_c;
			end
			SEC_CYAN: begin
				m_r = MW'(SECT_W); m_g = rem;       m_b = '0;
			end
			SEC_BLUE: begin
				m_r = rem_c;      m_g = MW'(SECT_W); m_b = '0;
			end
			default: begin
				m_r = '0;         m_g = MW'(SECT_W); m_b = rem;
			end
		endcase
	end

	// Stage 1: hold weights and levels
	always_ff @(posedge clk) begin
		if (adv1) begin
			sat_s1 <= pix_in.saturation;
			val_s1 <= pix_in.brightness;
			m_r_s1 <= m_r;
			m_g_s1 <= m_g;
			m_b_s1 <= m_b;
		end
	end

	// Stages 2 to 5: one lane per channel
	hsv2rgb_chan #(
		.HUE_FRAC_BITS   (HUE_FRAC_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_chan_r (
		.clk          (clk),
		.ld           (ld),
		.sat_s1       (sat_s1),
		.val_s1       (val_s1),
		.weight_s1    (m_r_s1),
		.chan_byte_s5 (red_s5)
	);

	hsv2rgb_chan #(
		.HUE_FRAC_BITS   (HUE_FRAC_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_chan_g (
		.clk          (clk),
		.ld           (ld),
		.sat_s1       (sat_s1),
		.val_s1       (val_s1),
		.weight_s1    (m_g_s1),
		.chan_byte_s5 (green_s5)
	);

	hsv2rgb_chan #(
		.HUE_FRAC_BITS   (HUE_FRAC_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_chan_b (
		.clk          (clk),
		.ld           (ld),
		.sat_s1       (sat_s1),
		.val_s1       (val_s1),
		.weight_s1    (m_b_s1),
		.chan_byte_s5 (blue_s5)
	);

	// Drive the output transfer
	assign pix_out.valid       = vld_s5;
	assign pix_out.red         = red_s5;
	assign pix_out.green       = green_s5;
	assign pix_out.blue        = blue_s5;
	assign pix_out.packed_argb = {hsv2rgb_pkg::ALPHA_BYTE, red_s5, green_s5, blue_s5};

	// Input is refused only when every stage is occupied
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5))
		else $error("input blocked while a stage is empty");

	// A stalled first stage keeps its pixel
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv2) |=> (vld_s1 && $stable(m_r_s1) && $stable(val_s1)))
		else $error("first stage lost its pixel during a stall");

	// Channel weights never exceed one sector width
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (32'(m_r_s1) <= SECT_W && 32'(m_g_s1) <= SECT_W
			&& 32'(m_b_s1) <= SECT_W))
		else $error("channel weight out of range");

endmodule
